// ===== design/svt_pkg.sv =====
// Shared types, constants and helpers for the skinned vertex transform.
package svt_pkg;

    localparam int ROWS_PER_BONE = 3;
    localparam int WEIGHT_FRAC   = 15;

    // command codes on the input beat
    localparam logic [1:0] CMD_PAL = 2'd0;
    localparam logic [1:0] CMD_XF  = 2'd1;
    localparam logic [1:0] CMD_VTX = 2'd2;

    // job kinds after classification
    localparam logic [1:0] K_IDLE = 2'd0;
    localparam logic [1:0] K_PAL  = 2'd1;
    localparam logic [1:0] K_XF   = 2'd2;
    localparam logic [1:0] K_VTX  = 2'd3;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [7:0]         row_index;
        logic signed [31:0] lane_x;
        logic signed [31:0] lane_y;
        logic signed [31:0] lane_z;
        logic signed [31:0] lane_w;
        logic [63:0]        blend_weights;
        logic [31:0]        bone_indices;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] clip_x;
        logic signed [31:0] clip_y;
        logic signed [31:0] clip_z;
        logic signed [31:0] clip_w;
        logic               was_skinned;
    } t_out_beat;

    // what rides along the back pipeline
    typedef struct packed {
        logic [1:0]       kind;
        logic             pass;     // all raw weights zero
        logic [1:0]       row_sel;  // palette row within bone, or transform row
        logic [3:0][31:0] lanes;    // x in lane 0
    } t_tag;

    typedef struct packed {
        t_tag             tag;
        logic [3:0][7:0]  bone;     // palette loads use slot 0
        logic [3:0][15:0] weight;   // zeroed for out-of-range bones
    } t_job;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end
        if (x < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

endpackage

// ===== design/svt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module svt_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/svt_front.sv =====
// Front end: decodes an input beat into a back-end job.
module svt_front #(
    parameter int BONES = 64
) (
    input  logic              i_accept,
    input  svt_pkg::t_in_beat i_beat,
    output logic              o_push,
    output svt_pkg::t_job     o_job
);
    import svt_pkg::*;

    logic [15:0] w_q16;
    logic [7:0]  w_pal_bone;
    logic [7:0]  w_pal_rem;
    t_job        w_job;

    always_comb begin
        // row / 3 by reciprocal, exact for 8-bit rows
        w_q16      = {8'd0, i_beat.row_index} * 16'd171;
        w_pal_bone = {1'b0, w_q16[15:9]};
        w_pal_rem  = i_beat.row_index - {w_pal_bone[6:0], 1'b0} - w_pal_bone;

        w_job.tag.kind    = K_IDLE;
        w_job.tag.pass    = (i_beat.blend_weights == 64'd0);
        w_job.tag.row_sel = 2'd0;
        w_job.tag.lanes   = {i_beat.lane_w, i_beat.lane_z, i_beat.lane_y, i_beat.lane_x};
        w_job.bone        = i_beat.bone_indices;
        for (int s = 0; s < 4; s++) begin
            w_job.weight[s] = ({1'b0, i_beat.bone_indices[8*s +: 8]} < 9'(BONES))
                              ? i_beat.blend_weights[16*s +: 16] : 16'd0;
        end

        case (i_beat.cmd)
            CMD_PAL: begin
                if ({2'b00, i_beat.row_index} < 10'(BONES * ROWS_PER_BONE)) begin
                    w_job.tag.kind    = K_PAL;
                    w_job.tag.row_sel = w_pal_rem[1:0];
                    w_job.bone[0]     = w_pal_bone;
                end
            end
            CMD_XF: begin
                if (i_beat.row_index < 8'd4) begin
                    w_job.tag.kind    = K_XF;
                    w_job.tag.row_sel = i_beat.row_index[1:0];
                end
            end
            CMD_VTX: begin
                w_job.tag.kind = K_VTX;
            end
            default: begin
                w_job.tag.kind = K_IDLE;
            end
        endcase
    end

    assign o_push = i_accept && (w_job.tag.kind != K_IDLE);
    assign o_job  = w_job;
endmodule

// ===== design/svt_queue.sv =====
// Two-entry job queue between front and back end.
module svt_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  svt_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output svt_pkg::t_job o_job
);
    import svt_pkg::*;

    t_job       r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_pop;

    assign w_pop = i_pop && (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_job;
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_slot[r_rp];
endmodule

// ===== design/svt_back.sv =====
// Back end: palette store, blend, skin and clip transform pipeline.
module svt_back #(
    parameter int BONES     = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  svt_pkg::t_job      i_job,
    output logic               o_done,
    output svt_pkg::t_out_beat o_result
);
    import svt_pkg::*;

    localparam int AW = (BONES > 1) ? $clog2(BONES) : 1;
    localparam logic signed [63:0] HALF_W = 64'sd1 <<< (WEIGHT_FRAC - 1);
    localparam logic signed [63:0] HALF_F = 64'sd1 <<< (FRAC_BITS - 1);

    t_tag               w_tag0;
    logic [127:0]       w_rd [4][3];
    logic               w_we [4][3];

    t_tag               r_t1, r_t2, r_t3, r_t4, r_t5, r_t6, r_t7;
    logic [3:0][15:0]   r_w1;
    logic signed [48:0] r_bp   [3][4][4];
    logic signed [48:0] n_bp   [3][4][4];
    logic signed [50:0] r_acc  [3][4];
    logic signed [50:0] n_acc  [3][4];
    logic signed [31:0] r_m    [3][4];
    logic signed [31:0] n_m    [3][4];
    logic signed [63:0] r_pp   [3][4];
    logic signed [63:0] n_pp   [3][4];
    logic signed [31:0] r_skin [3];
    logic signed [31:0] n_skin [3];
    logic signed [63:0] r_tp   [4][4];
    logic signed [63:0] n_tp   [4][4];
    logic signed [31:0] r_xf   [4][4];
    t_out_beat          r_out;
    t_out_beat          n_out;
    logic               r_done;

    always_comb begin
        w_tag0 = i_job.tag;
        if (!i_valid) begin
            w_tag0.kind = K_IDLE;
        end
    end

    // one RAM per (slot, bone row) so a vertex reads all twelve rows at once
    for (genvar s = 0; s < 4; s++) begin : g_slot
        for (genvar r = 0; r < ROWS_PER_BONE; r++) begin : g_row
            assign w_we[s][r] = (w_tag0.kind == K_PAL) && (w_tag0.row_sel == 2'(r));
            svt_ram #(
                .WIDTH(128),
                .DEPTH(BONES)
            ) u_ram (
                .i_clk  (i_clk),
                .i_we   (w_we[s][r]),
                .i_waddr(i_job.bone[0][AW-1:0]),
                .i_wdata(i_job.tag.lanes),
                .i_raddr(i_job.bone[s][AW-1:0]),
                .o_rdata(w_rd[s][r])
            );
        end
    end

    // element * weight; a zero weight forces zero so unread rows never leak in
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 4; k++) begin
                for (int s = 0; s < 4; s++) begin
                    n_bp[r][k][s] = (r_w1[s] != 16'd0)
                        ? 49'($signed(w_rd[s][r][32*k +: 32])) * 49'($signed({1'b0, r_w1[s]}))
                        : 49'sd0;
                end
            end
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 4; k++) begin
                n_acc[r][k] = 51'(r_bp[r][k][0]) + 51'(r_bp[r][k][1])
                            + 51'(r_bp[r][k][2]) + 51'(r_bp[r][k][3]);
                n_m[r][k]   = sat32((64'(r_acc[r][k]) + HALF_W) >>> WEIGHT_FRAC);
                n_pp[r][k]  = 64'($signed(r_t4.lanes[k])) * 64'(r_m[r][k]);
            end
        end
    end

    always_comb begin
        logic signed [63:0] sum;
        for (int r = 0; r < 3; r++) begin
            sum = 64'sd0;
            for (int k = 0; k < 4; k++) begin
                sum = sum + ((r_pp[r][k] + HALF_F) >>> FRAC_BITS);
            end
            n_skin[r] = sat32(sum);
        end
    end

    always_comb begin
        logic signed [31:0] sk;
        for (int i = 0; i < 4; i++) begin
            for (int k = 0; k < 4; k++) begin
                sk = (k < 3) ? r_skin[k] : $signed(r_t6.lanes[3]);
                n_tp[i][k] = 64'(r_xf[i][k]) * 64'(sk);
            end
        end
    end

    always_comb begin
        logic signed [63:0] sum;
        logic signed [31:0] clip [4];
        for (int i = 0; i < 4; i++) begin
            sum = 64'sd0;
            for (int k = 0; k < 4; k++) begin
                sum = sum + ((r_tp[i][k] + HALF_F) >>> FRAC_BITS);
            end
            clip[i] = sat32(sum);
        end
        if (r_t7.pass) begin
            n_out.clip_x      = $signed(r_t7.lanes[0]);
            n_out.clip_y      = $signed(r_t7.lanes[1]);
            n_out.clip_z      = $signed(r_t7.lanes[2]);
            n_out.clip_w      = $signed(r_t7.lanes[3]);
            n_out.was_skinned = 1'b0;
        end else begin
            n_out.clip_x      = clip[0];
            n_out.clip_y      = clip[1];
            n_out.clip_z      = clip[2];
            n_out.clip_w      = clip[3];
            n_out.was_skinned = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1   <= '0;
            r_t2   <= '0;
            r_t3   <= '0;
            r_t4   <= '0;
            r_t5   <= '0;
            r_t6   <= '0;
            r_t7   <= '0;
            r_done <= 1'b0;
        end else begin
            r_t1   <= w_tag0;
            r_t2   <= r_t1;
            r_t3   <= r_t2;
            r_t4   <= r_t3;
            r_t5   <= r_t4;
            r_t6   <= r_t5;
            r_t7   <= r_t6;
            r_done <= (r_t7.kind == K_VTX);
        end
    end

    always_ff @(posedge i_clk) begin
        r_w1   <= i_job.weight;
        r_bp   <= n_bp;
        r_acc  <= n_acc;
        r_m    <= n_m;
        r_pp   <= n_pp;
        r_skin <= n_skin;
        r_tp   <= n_tp;
        r_out  <= n_out;
        // transform rows update at the stage that reads them, keeping order
        if (r_t6.kind == K_XF) begin
            for (int k = 0; k < 4; k++) begin
                r_xf[r_t6.row_sel][k] <= $signed(r_t6.lanes[k]);
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_out;
endmodule

// ===== design/skinned_vertex_transform.sv =====
// Top level of the four-bone skinning and clip transform block.
//
//  channel   | handshake           | beat
//  ----------+---------------------+---------------------------------------
//  command   | start / busy        | i_beat  (t_in_beat: cmd, row, lanes,
//            |                     |          weights, bone numbers)
//  result    | o_done (one cycle)  | o_result (t_out_beat: clip xyzw,
//            |                     |          was_skinned)
//
// One beat per cycle is taken while busy is low; the queue slot of each vertex is
// written at the edge that accepts it, and o_done rises once the vertex has passed
// the back pipeline's eight register stages (RAM read, products, sums, blend round,
// skin products, skin sums, transform products, output).
// Loads produce no result and move through the same pipeline in order,
// so a vertex always sees every load accepted ahead of it.
// Reset is synchronous and clears only pipeline control; the palette and
// transform hold garbage until loaded.
// The receiver cannot stall, so the back end never stops; busy only
// rises if the two-entry queue fills, which steady traffic never does.
module skinned_vertex_transform #(
    parameter int BONES     = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  svt_pkg::t_in_beat  i_beat,
    output logic               o_done,
    output svt_pkg::t_out_beat o_result
);
    import svt_pkg::*;

    logic w_accept;
    logic w_push;
    t_job w_job_in;
    logic w_full;
    logic w_valid;
    t_job w_job_out;

    assign w_accept = start && !w_full;
    assign busy     = w_full;

    // decode and range-check commands, gate weights of absent bones
    svt_front #(
        .BONES(BONES)
    ) u_front (
        .i_accept(w_accept),
        .i_beat  (i_beat),
        .o_push  (w_push),
        .o_job   (w_job_in)
    );

    svt_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_job  (w_job_in),
        .i_pop  (w_valid),
        .o_full (w_full),
        .o_valid(w_valid),
        .o_job  (w_job_out)
    );

    // palette RAMs, blend, skin, transform, saturate
    svt_back #(
        .BONES    (BONES),
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid),
        .i_job   (w_job_out),
        .o_done  (o_done),
        .o_result(o_result)
    );
endmodule

// ===== tb/skinned_vertex_transform_tb.sv =====
// Self-checking testbench for the skinned vertex transform block.
`timescale 1ns / 1ps

module skinned_vertex_transform_tb;
    import svt_pkg::*;

    localparam int BONES     = 64;
    localparam int FRAC_BITS = 16;
    localparam int PAL_ROWS  = BONES * ROWS_PER_BONE;
    localparam int LATENCY   = 10;
    localparam int WDOG_MAX  = 5000;
    localparam int N_RANDOM  = 380;
    localparam logic [1:0] CMD_NONE = 2'd3;   // unused code, block ignores it

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_in_beat   i_beat;
    logic       o_done;
    t_out_beat  o_result;

    skinned_vertex_transform #(.BONES(BONES), .FRAC_BITS(FRAC_BITS)) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_beat   (i_beat),
        .o_done   (o_done),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Shadow copies of the block's storage.
    logic signed [31:0] pal_shadow [PAL_ROWS][4];
    logic signed [31:0] xf_shadow  [4][4];

    t_out_beat clip_queue [$];   // predicted results, oldest first
    int  n_errors;
    int  n_vertices;
    int  n_skinned;
    int  n_beats;
    int  idle_cycles;

    // Round: add half, arithmetic shift (floor).
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] x,
                                                     input int s);
        logic signed [63:0] t;
        t = x + (64'sd1 <<< (s - 1));
        return t >>> s;
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] x);
        if (x > 64'sd2147483647)
            return 32'sh7fffffff;
        if (x < -64'sd2147483648)
            return 32'sh80000000;
        return x[31:0];
    endfunction

    // Update storage shadows and compute the expected clip-space result.
    function automatic bit skin_predict(input t_in_beat b, output t_out_beat r);
        logic signed [63:0] acc [3][4];
        logic signed [63:0] pos [4];
        logic signed [63:0] skin [4];
        logic signed [63:0] sum;
        logic signed [63:0] wt;
        logic signed [31:0] m;
        int bn;
        r = '0;
        case (b.cmd)
            CMD_PAL: begin
                if (b.row_index < PAL_ROWS) begin
                    pal_shadow[b.row_index] = '{b.lane_x, b.lane_y, b.lane_z, b.lane_w};
                end
                return 1'b0;
            end
            CMD_XF: begin
                if (b.row_index < 4) begin
                    xf_shadow[b.row_index] = '{b.lane_x, b.lane_y, b.lane_z, b.lane_w};
                end
                return 1'b0;
            end
            CMD_VTX: ;
            default: return 1'b0;
        endcase
        pos = '{b.lane_x, b.lane_y, b.lane_z, b.lane_w};
        if (b.blend_weights == '0) begin
            r = '{b.lane_x, b.lane_y, b.lane_z, b.lane_w, 1'b0};
            return 1'b1;
        end
        foreach (acc[i, k]) acc[i][k] = 0;
        for (int s = 0; s < 4; s++) begin
            wt = {48'd0, b.blend_weights[16*s +: 16]};
            bn = b.bone_indices[8*s +: 8];
            if (wt == 0 || bn >= BONES) continue;
            for (int i = 0; i < 3; i++)
                for (int k = 0; k < 4; k++)
                    acc[i][k] += 64'(pal_shadow[bn*3 + i][k]) * wt;
        end
        for (int i = 0; i < 3; i++) begin
            sum = 0;
            for (int k = 0; k < 4; k++) begin
                m = clamp32(rnd_shift(acc[i][k], WEIGHT_FRAC));
                sum += rnd_shift(pos[k] * 64'(m), FRAC_BITS);
            end
            skin[i] = clamp32(sum);
        end
        skin[3] = pos[3];
        r.clip_x = 0;
        for (int i = 0; i < 4; i++) begin
            sum = 0;
            for (int k = 0; k < 4; k++)
                sum += rnd_shift(64'(xf_shadow[i][k]) * skin[k], FRAC_BITS);
            case (i)
                0: r.clip_x = clamp32(sum);
                1: r.clip_y = clamp32(sum);
                2: r.clip_z = clamp32(sum);
                default: r.clip_w = clamp32(sum);
            endcase
        end
        r.was_skinned = 1'b1;
        return 1'b1;
    endfunction

    // Result monitor: every strobe is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            t_out_beat exp_r;
            if (clip_queue.size() == 0) begin
                $error("result with nothing expected: %h", o_result);
                n_errors++;
            end else begin
                exp_r = clip_queue.pop_front();
                if (o_result.clip_x !== exp_r.clip_x) begin
                    $error("clip_x exp %h got %h", exp_r.clip_x, o_result.clip_x);
                    n_errors++;
                end
                if (o_result.clip_y !== exp_r.clip_y) begin
                    $error("clip_y exp %h got %h", exp_r.clip_y, o_result.clip_y);
                    n_errors++;
                end
                if (o_result.clip_z !== exp_r.clip_z) begin
                    $error("clip_z exp %h got %h", exp_r.clip_z, o_result.clip_z);
                    n_errors++;
                end
                if (o_result.clip_w !== exp_r.clip_w) begin
                    $error("clip_w exp %h got %h", exp_r.clip_w, o_result.clip_w);
                    n_errors++;
                end
                if (o_result.was_skinned !== exp_r.was_skinned) begin
                    $error("was_skinned exp %b got %b", exp_r.was_skinned,
                           o_result.was_skinned);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog: cycles with neither an accepted command nor a result.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("watchdog expired");
            $display("FAIL skinned_vertex_transform");
            $finish;
        end
    end

    // Drive one beat and predict at acceptance; start drops only for a gap.
    task automatic send_beat(input t_in_beat b, input int gap);
        t_out_beat r;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_beat <= b;
        do @(posedge i_clk); while (busy);
        if (skin_predict(b, r)) begin
            clip_queue.push_back(r);
            n_vertices++;
            n_skinned += r.was_skinned;
        end
        n_beats++;
    endtask

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;         // back-to-back stretches
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);  // occasional long gap
    endfunction

    function automatic logic [31:0] rand_lane();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom;
            default: return 32'($signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000);
        endcase
    endfunction

    // Bone number among the loaded palette entries, or out of range.
    function automatic logic [7:0] rand_bone(input int n_loaded);
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(BONES, 255));
        return 8'($urandom_range(0, n_loaded - 1));
    endfunction

    function automatic t_in_beat mk(input logic [1:0] c, input logic [7:0] row,
                                    input logic [31:0] x, y, z, w,
                                    input logic [63:0] wts, input logic [31:0] bones);
        t_in_beat b;
        b.cmd = c; b.row_index = row;
        b.lane_x = x; b.lane_y = y; b.lane_z = z; b.lane_w = w;
        b.blend_weights = wts; b.bone_indices = bones;
        return b;
    endfunction

    t_in_beat  dir_beats [$];
    t_out_beat dir_known [$];   // typed-in results for the rows flagged in dir_has
    bit        dir_has   [$];

    initial begin
        t_in_beat b;
        t_out_beat r;
        int cnt;
        int bones_ready;
        n_errors = 0; n_vertices = 0; n_skinned = 0; n_beats = 0;
        idle_cycles = 0;
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_beat  = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table. Pass-through rows carry their result; the rest go to
        // the predictor. Ignored loads and the unused command sit among them.
        dir_beats = '{
            // pass-through extremes, before anything is loaded
            mk(CMD_VTX, 8'd0,   32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff,
               64'd0, 32'hffffffff),
            mk(CMD_VTX, 8'd255, 32'h80000000, 32'h7fffffff, 32'h00010000, 32'h0,
               64'd0, 32'h0),
            // identity transform
            mk(CMD_XF, 8'd0, 32'h00010000, 0, 0, 0, 64'd0, 0),
            mk(CMD_XF, 8'd1, 0, 32'h00010000, 0, 0, 64'd0, 0),
            mk(CMD_XF, 8'd2, 0, 0, 32'h00010000, 0, 64'd0, 0),
            mk(CMD_XF, 8'd3, 0, 0, 0, 32'h00010000, 64'd0, 0),
            mk(CMD_XF, 8'd4, 32'hdeadbeef, 1, 2, 3, 64'd0, 0),          // ignored
            // bone 0 identity, bone 1 = 2x with offsets, last bone extremes
            mk(CMD_PAL, 8'd0, 32'h00010000, 0, 0, 0, 64'd0, 0),
            mk(CMD_PAL, 8'd1, 0, 32'h00010000, 0, 0, 64'd0, 0),
            mk(CMD_PAL, 8'd2, 0, 0, 32'h00010000, 0, 64'd0, 0),
            mk(CMD_PAL, 8'd3, 32'h00020000, 0, 0, 32'h00050000, 64'd0, 0),
            mk(CMD_PAL, 8'd4, 0, 32'h00020000, 0, 32'hfffb0000, 64'd0, 0),
            mk(CMD_PAL, 8'd5, 0, 0, 32'h00020000, 32'h00008000, 64'd0, 0),
            mk(CMD_PAL, 8'(PAL_ROWS-3), 32'h7fffffff, 32'h80000000, 32'h7fffffff,
               32'h80000000, 64'd0, 0),
            mk(CMD_PAL, 8'(PAL_ROWS-2), 32'h80000000, 32'h7fffffff, 32'h80000000,
               32'h7fffffff, 64'd0, 0),
            mk(CMD_PAL, 8'(PAL_ROWS-1), 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
               32'h7fffffff, 64'd0, 0),
            mk(CMD_PAL, 8'd255, 32'h12345678, 0, 0, 0, 64'd0, 0),       // ignored
            mk(CMD_NONE, 8'd0, 1, 2, 3, 4, 64'h1, 32'h0),                  // ignored
            // full weight on bone 0, weights in one slot only, others zero
            mk(CMD_VTX, 8'd0, 32'h00010000, 32'h00020000, 32'h00030000, 32'h00010000,
               64'h0000_0000_0000_8000, 32'h0),
            // split between bones 0 and 1 in slots 1 and 3
            mk(CMD_VTX, 8'd0, 32'hfff00000, 32'h00100000, 32'h00000001, 32'h00010000,
               64'h4000_0000_4000_0000, 32'h01_00_00_00),
            // out-of-range bones in two slots with weight
            mk(CMD_VTX, 8'd0, 32'h00010000, 32'h00010000, 32'h00010000, 32'h00010000,
               64'h8000_8000_8000_8000, 32'hff_40_01_00),
            // max weights on the extreme bone: saturation everywhere
            mk(CMD_VTX, 8'd0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
               64'hffff_ffff_ffff_ffff, {4{8'(BONES-1)}}),
            // all slots on a bone out of range: skinned, matrix zero
            mk(CMD_VTX, 8'd0, 32'h00010000, 32'h00020000, 32'h00030000, 32'h7fffffff,
               64'h0001_0001_0001_0001, {4{8'd200}})
        };
        dir_has = '{1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
        dir_known = '{'{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff, 1'b0},
                      '{32'h80000000, 32'h7fffffff, 32'h00010000, 32'h0, 1'b0}};

        foreach (dir_beats[i]) begin
            if (dir_has[i]) begin
                // check the typed-in result against the predictor's own view too
                void'(skin_predict(dir_beats[i], r));
                if (r !== dir_known[i]) begin
                    $error("table row %0d: exp %h predictor %h", i, dir_known[i], r);
                    n_errors++;
                end
            end
            send_beat(dir_beats[i], pick_gap());
        end
        start <= 1'b0;

        // Sender holds off until the pipeline has drained completely.
        wait (clip_queue.size() == 0);
        repeat (LATENCY + 2) @(posedge i_clk);

        // Load the whole palette and a random transform so every read is legal.
        for (int row = 0; row < PAL_ROWS; row++)
            send_beat(mk(CMD_PAL, 8'(row), rand_lane(), rand_lane(), rand_lane(),
                         rand_lane(), {$urandom, $urandom}, $urandom), pick_gap());
        for (int row = 0; row < 4; row++)
            send_beat(mk(CMD_XF, 8'(row), rand_lane(), rand_lane(), rand_lane(),
                         rand_lane(), 64'd0, 0), pick_gap());
        bones_ready = BONES;

        // Random mix: mostly vertices, with reloads and ignored noise.
        cnt = 0;
        while (cnt < N_RANDOM) begin
            int p;
            p = $urandom_range(0, 99);
            if (p < 70) begin
                logic [63:0] wts;
                wts = {$urandom, $urandom};
                for (int s = 0; s < 4; s++)
                    if ($urandom_range(0, 3) == 0) wts[16*s +: 16] = '0;
                if ($urandom_range(0, 15) == 0) wts = '0;
                b = mk(CMD_VTX, 8'($urandom), rand_lane(), rand_lane(), rand_lane(),
                       rand_lane(), wts,
                       {rand_bone(bones_ready), rand_bone(bones_ready),
                        rand_bone(bones_ready), rand_bone(bones_ready)});
                cnt++;
            end else if (p < 85) begin
                b = mk(CMD_PAL, 8'($urandom_range(0, 255)), rand_lane(), rand_lane(),
                       rand_lane(), rand_lane(), {$urandom, $urandom}, $urandom);
                cnt++;
            end else if (p < 95) begin
                b = mk(CMD_XF, 8'($urandom_range(0, 7)), rand_lane(), rand_lane(),
                       rand_lane(), rand_lane(), {$urandom, $urandom}, $urandom);
                cnt++;
            end else begin
                b = mk(CMD_NONE, 8'($urandom), $urandom, $urandom, $urandom, $urandom,
                       {$urandom, $urandom}, $urandom);
            end
            send_beat(b, pick_gap());
        end
        start <= 1'b0;

        wait (clip_queue.size() == 0);
        repeat (LATENCY + 5) @(posedge i_clk);

        $display("%0d beats accepted, %0d vertices checked (%0d skinned, rest passed through)",
                 n_beats, n_vertices, n_skinned);
        if (n_errors == 0)
            $display("PASS skinned_vertex_transform");
        else
            $display("FAIL skinned_vertex_transform");
        $finish;
    end

endmodule
